// ===== src/assert_macros.svh =====
// Assertion helpers shared by the encoder modules.
// Each macro samples on aclk and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define HTE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define HTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/hte_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_pkg: shared types and constants of the Huffman table encoder
// Opcodes, result kinds, table entry and emitter control structures.
// ----------------------------------------------------------------------------
package hte_pkg;

    localparam int MAX_CODE_LEN_DEF = 32;
    localparam int SYMBOL_COUNT_DEF = 256;

    localparam int SYM_W   = 8;
    localparam int LEN_W   = 6;
    localparam int CODE_W  = 32;
    localparam int TOTAL_W = 32;
    localparam int PEND_W  = 7;   // at most seven bits wait for a full byte
    localparam int CNTP_W  = 3;
    localparam int BYTE_W  = 8;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_FLUSH = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        TAIL_NONE  = 2'd0,
        TAIL_FLUSH = 2'd1,
        TAIL_ERROR = 2'd2
    } tail_t;

    typedef struct packed {
        logic              hit;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    typedef struct packed {
        tail_t              tail;
        logic [TOTAL_W-1:0] total;
    } em_ctrl_t;

endpackage

// ===== src/huffman_table_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_table_encoder: table-driven Huffman encoder with bit packer
// Loads per-symbol codes into a table, encodes symbols into a packed byte
// stream MSB first, flushes with zero padding and reports the bit total.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  tdata fields (low bit up)                    tuser  tlast
//  s_       in   symbol[7:0] code_len[13:8] code_bits[45:14]  op     -
//  m_       out  packed_byte[7:0] bit_total[39:8]             kind   last
//
//  An item enters every cycle unless the accumulate stage waits on a busy
//  serializer; the output port carries one result per cycle while m_tready is
//  high, so an encode that completes N bytes can hold the input once the serializer backs up.
//  Pipeline: table read -> accumulate stage -> serializer -> m_ reg.
//  A symbol's first result passes the table read register, the serializer
//  registers and the m_ register before it is valid on m_.
//  Reset clears the table's valid bits, the pending bits and the bit total
//  at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_table_encoder #(
    parameter int MAX_CODE_LEN = hte_pkg::MAX_CODE_LEN_DEF,
    parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // symbol[7:0], code_len[13:8], code_bits[45:14], zero
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // packed_byte[7:0], bit_total[39:8]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);

    localparam int ACC_W = MAX_CODE_LEN + hte_pkg::PEND_W;
    localparam int CNT_W = $clog2(ACC_W+1);
    localparam int NB_W  = $clog2(ACC_W/hte_pkg::BYTE_W+1);

    // Input decode.
    hte_pkg::op_t                s_op;
    logic [hte_pkg::SYM_W-1:0]   s_sym;
    logic [hte_pkg::LEN_W-1:0]   s_len;
    logic [hte_pkg::CODE_W-1:0]  s_bits;
    logic [hte_pkg::CODE_W-1:0]  code_mask;
    logic                        s_fire;
    logic                        len_ok;

    // Accumulate stage (the item whose table read just returned).
    logic                        a_valid_reg;
    hte_pkg::op_t                a_op_reg;
    hte_pkg::entry_t             tbl_rd;
    logic                        a_adv;
    logic                        needs_emit;

    // Bit packer state.
    logic [hte_pkg::PEND_W-1:0]  pend_reg, pend_next;
    logic [hte_pkg::CNTP_W-1:0]  pcount_reg, pcount_next;
    logic [hte_pkg::TOTAL_W-1:0] emitted_reg, emitted_next;

    logic [ACC_W-1:0]            acc_enc;
    logic [CNT_W-1:0]            cnt_enc;
    logic [NB_W-1:0]             nb_enc;
    logic [hte_pkg::PEND_W-1:0]  pend_enc;
    logic [hte_pkg::TOTAL_W-1:0] total_enc;
    logic [hte_pkg::BYTE_W-1:0]  fl_byte;

    // Serializer load.
    logic [ACC_W-1:0]            em_acc;
    logic [CNT_W-1:0]            em_cnt;
    logic [NB_W-1:0]             em_nb;
    hte_pkg::em_ctrl_t           em_ctrl;
    logic                        em_ready;
    logic                        em_load;
    logic [hte_pkg::BYTE_W-1:0]  out_byte;
    logic [hte_pkg::TOTAL_W-1:0] out_total;
    hte_pkg::kind_t              out_kind;

    assign s_op   = hte_pkg::op_t'(s_tuser[1:0]);
    assign s_sym  = s_tdata[7:0];
    assign s_len  = s_tdata[13:8];
    assign s_bits = s_tdata[45:14];
    assign s_fire = s_tvalid && s_tready;

    // Drop loads with a length beyond the supported maximum; mask unused bits.
    assign len_ok    = s_len <= hte_pkg::LEN_W'(MAX_CODE_LEN);
    assign code_mask = (s_len >= hte_pkg::LEN_W'(hte_pkg::CODE_W)) ? '1
                     : ~({hte_pkg::CODE_W{1'b1}} << s_len);

    hte_table #(
        .SYMBOL_COUNT (SYMBOL_COUNT)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (s_fire && (s_op == hte_pkg::OP_ENCODE)),
        .wr_en    (s_fire && (s_op == hte_pkg::OP_LOAD) && len_ok),
        .clr      (s_fire && (s_op == hte_pkg::OP_CLEAR)),
        .addr     (s_sym),
        .wr_len   (s_len),
        .wr_code  (s_bits & code_mask),
        .rd_entry (tbl_rd)
    );

    // Append the code below the pending bits; split into bytes and remainder.
    always_comb begin
        acc_enc   = (ACC_W'(pend_reg) << tbl_rd.len) | ACC_W'(tbl_rd.code);
        cnt_enc   = CNT_W'(pcount_reg) + CNT_W'(tbl_rd.len);
        nb_enc    = NB_W'(cnt_enc >> 3);
        pend_enc  = acc_enc[hte_pkg::PEND_W-1:0]
                  & hte_pkg::PEND_W'((8'd1 << cnt_enc[2:0]) - 8'd1);
        total_enc = emitted_reg + hte_pkg::TOTAL_W'(tbl_rd.len);
        // Left-justify the pending bits, zero padded (shift by 8 - count).
        fl_byte   = hte_pkg::BYTE_W'({1'b0, pend_reg} << (3'd0 - pcount_reg));
    end

    // Build the serializer load for the item in the accumulate stage.
    always_comb begin
        em_acc        = '0;
        em_cnt        = '0;
        em_nb         = '0;
        em_ctrl.tail  = hte_pkg::TAIL_NONE;
        em_ctrl.total = emitted_reg;
        needs_emit    = 1'b0;
        unique case (a_op_reg)
            hte_pkg::OP_ENCODE: begin
                if (!tbl_rd.hit) begin
                    needs_emit   = 1'b1;
                    em_ctrl.tail = hte_pkg::TAIL_ERROR;
                end else begin
                    em_acc        = acc_enc;
                    em_cnt        = cnt_enc;
                    em_nb         = nb_enc;
                    em_ctrl.total = total_enc;
                    needs_emit    = (nb_enc != '0);
                end
            end
            hte_pkg::OP_FLUSH: begin
                needs_emit   = 1'b1;
                em_acc       = ACC_W'(fl_byte);
                em_cnt       = CNT_W'(hte_pkg::BYTE_W);
                em_nb        = NB_W'(pcount_reg != '0);
                em_ctrl.tail = hte_pkg::TAIL_FLUSH;
            end
            hte_pkg::OP_LOAD, hte_pkg::OP_CLEAR: begin
            end
        endcase
    end

    // Advance unless results are due and the serializer is still busy.
    assign a_adv    = a_valid_reg && (!needs_emit || em_ready);
    assign em_load  = a_valid_reg && needs_emit;
    assign s_tready = !a_valid_reg || a_adv;

    // Packer state update as the item leaves the accumulate stage.
    always_comb begin
        pend_next    = pend_reg;
        pcount_next  = pcount_reg;
        emitted_next = emitted_reg;
        if (a_adv) begin
            unique case (a_op_reg)
                hte_pkg::OP_ENCODE: begin
                    if (tbl_rd.hit) begin
                        pend_next    = pend_enc;
                        pcount_next  = cnt_enc[2:0];
                        emitted_next = total_enc;
                    end
                end
                hte_pkg::OP_FLUSH, hte_pkg::OP_CLEAR: begin
                    pend_next    = '0;
                    pcount_next  = '0;
                    emitted_next = '0;
                end
                hte_pkg::OP_LOAD: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            pend_reg    <= '0;
            pcount_reg  <= '0;
            emitted_reg <= '0;
        end else begin
            if (s_tready) begin
                a_valid_reg <= s_tvalid;
            end
            pend_reg    <= pend_next;
            pcount_reg  <= pcount_next;
            emitted_reg <= emitted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_op_reg <= s_op;
        end
    end

    hte_emitter #(
        .ACC_W (ACC_W)
    ) u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load_valid (em_load),
        .load_ready (em_ready),
        .load_acc   (em_acc),
        .load_cnt   (em_cnt),
        .load_nb    (em_nb),
        .load_ctrl  (em_ctrl),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_byte     (out_byte),
        .m_total    (out_total),
        .m_kind     (out_kind),
        .m_last     (m_tlast)
    );

    assign m_tdata = {out_total, out_byte};
    assign m_tuser = out_kind;

    `HTE_ASSERT(a_pend_clean, (pend_reg >> pcount_reg) == '0, "stale bits above pending count")
    `HTE_ASSERT(a_stall_full, s_tready || a_valid_reg, "input stalled with empty accumulate stage")
    `HTE_ASSERT_NEXT(a_flush_zeroes, a_adv && (a_op_reg == hte_pkg::OP_FLUSH), (pcount_reg == '0) && (emitted_reg == '0), "flush left packer state")

endmodule

// ===== src/hte_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_table: code table storage
// One synchronous memory of length and code per symbol, plus a valid bit per
// entry in flops so that a clear takes effect at once. Registered read.
// ----------------------------------------------------------------------------
module hte_table #(
    parameter int SYMBOL_COUNT = hte_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic                       wr_en,
    input  logic                       clr,
    input  logic [hte_pkg::SYM_W-1:0]  addr,
    input  logic [hte_pkg::LEN_W-1:0]  wr_len,
    input  logic [hte_pkg::CODE_W-1:0] wr_code,
    output hte_pkg::entry_t            rd_entry
);

    localparam int AW = $clog2(SYMBOL_COUNT);
    localparam int DW = hte_pkg::LEN_W + hte_pkg::CODE_W;

    logic [DW-1:0]           mem [SYMBOL_COUNT];
    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic                    hit_reg;
    logic [DW-1:0]           rd_data_reg;
    logic                    in_range;
    logic [AW-1:0]           idx;

    assign idx      = addr[AW-1:0];
    assign in_range = {1'b0, addr} < (hte_pkg::SYM_W + 1)'(SYMBOL_COUNT);

    always_ff @(posedge aclk) begin
        if (wr_en && in_range) begin
            mem[idx] <= {wr_len, wr_code};
        end
        if (rd_en) begin
            rd_data_reg <= mem[idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end else begin
            if (clr) begin
                valid_reg <= '0;
            end else if (wr_en && in_range) begin
                valid_reg[idx] <= 1'b1;
            end
            if (rd_en) begin
                hit_reg <= in_range && valid_reg[idx];
            end
        end
    end

    assign rd_entry.hit  = hit_reg;
    assign rd_entry.len  = rd_data_reg[DW-1 -: hte_pkg::LEN_W];
    assign rd_entry.code = rd_data_reg[hte_pkg::CODE_W-1:0];

endmodule

// ===== src/hte_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hte_emitter: result serializer
// Holds one item's accumulated bits and emits its completed bytes, then an
// optional flush or error result, one per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hte_emitter #(
    parameter int ACC_W = hte_pkg::MAX_CODE_LEN_DEF + hte_pkg::PEND_W
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         load_valid,
    output logic                                         load_ready,
    input  logic [ACC_W-1:0]                             load_acc,
    input  logic [$clog2(ACC_W+1)-1:0]                   load_cnt,
    input  logic [$clog2(ACC_W/hte_pkg::BYTE_W+1)-1:0]   load_nb,
    input  hte_pkg::em_ctrl_t                            load_ctrl,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    output logic [hte_pkg::BYTE_W-1:0]                   m_byte,
    output logic [hte_pkg::TOTAL_W-1:0]                  m_total,
    output hte_pkg::kind_t                               m_kind,
    output logic                                         m_last
);

    localparam int CNT_W  = $clog2(ACC_W+1);
    localparam int NB_MAX = ACC_W / hte_pkg::BYTE_W;
    localparam int NB_W   = $clog2(NB_MAX+1);

    logic [ACC_W-1:0]            acc_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [NB_W-1:0]             nb_reg, nb_next;
    hte_pkg::tail_t              tail_reg, tail_next;
    logic [hte_pkg::TOTAL_W-1:0] total_reg;

    logic                        m_valid_reg, m_valid_next;
    logic [hte_pkg::BYTE_W-1:0]  byte_out_reg;
    logic [hte_pkg::TOTAL_W-1:0] total_out_reg;
    hte_pkg::kind_t              kind_out_reg;
    logic                        last_out_reg;

    logic                        busy;
    logic                        out_free;
    logic                        step;
    logic                        final_res;
    logic                        load_fire;
    logic [hte_pkg::BYTE_W-1:0]  byte_sel;
    hte_pkg::kind_t              res_kind;

    always_comb begin
        busy      = (nb_reg != '0) || (tail_reg != hte_pkg::TAIL_NONE);
        out_free  = !m_valid_reg || m_tready;
        step      = busy && out_free;
        final_res = (nb_reg == '0)
                 || ((nb_reg == NB_W'(1)) && (tail_reg == hte_pkg::TAIL_NONE));
        load_ready = !busy || (step && final_res);
        load_fire  = load_valid && load_ready;
        byte_sel   = hte_pkg::BYTE_W'(acc_reg >> (cnt_reg - CNT_W'(hte_pkg::BYTE_W)));
        if (nb_reg != '0) begin
            res_kind = hte_pkg::KIND_BYTE;
        end else if (tail_reg == hte_pkg::TAIL_FLUSH) begin
            res_kind = hte_pkg::KIND_FLUSH;
        end else begin
            res_kind = hte_pkg::KIND_ERROR;
        end
    end

    // Serializer control: a load replaces the finished item, else advance.
    always_comb begin
        nb_next   = nb_reg;
        tail_next = tail_reg;
        if (load_fire) begin
            nb_next   = load_nb;
            tail_next = load_ctrl.tail;
        end else if (step) begin
            if (nb_reg != '0) begin
                nb_next = nb_reg - NB_W'(1);
            end else begin
                tail_next = hte_pkg::TAIL_NONE;
            end
        end
        if (step) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nb_reg      <= '0;
            tail_reg    <= hte_pkg::TAIL_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            nb_reg      <= nb_next;
            tail_reg    <= tail_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_fire) begin
            acc_reg   <= load_acc;
            cnt_reg   <= load_cnt;
            total_reg <= load_ctrl.total;
        end else if (step && (nb_reg != '0)) begin
            cnt_reg <= cnt_reg - CNT_W'(hte_pkg::BYTE_W);
        end
        if (step) begin
            byte_out_reg  <= (nb_reg != '0) ? byte_sel : '0;
            total_out_reg <= total_reg;
            kind_out_reg  <= res_kind;
            last_out_reg  <= final_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_byte   = byte_out_reg;
    assign m_total  = total_out_reg;
    assign m_kind   = kind_out_reg;
    assign m_last   = last_out_reg;

    `HTE_ASSERT(a_cnt_covers_bytes, (nb_reg == '0) || (cnt_reg >= CNT_W'(hte_pkg::BYTE_W)), "byte count exceeds held bits")
    `HTE_ASSERT(a_nb_bound, nb_reg <= NB_W'(NB_MAX), "byte count beyond accumulator size")
    `HTE_ASSERT(a_tail_is_last, !m_valid_reg || (kind_out_reg == hte_pkg::KIND_BYTE) || last_out_reg, "flush or error result not marked last")

endmodule

// ===== verif/tb_huffman_table_encoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_huffman_table_encoder: self-checking testbench of the table encoder
// Drives load, encode, flush and clear transactions into the s_ channel with
// random gaps and stalls on the m_ channel. A scoreboard mirrors the code
// table and the bit packer, queues the byte, flush and error results each
// transaction should produce, and checks every m_ transaction in order.
// ----------------------------------------------------------------------------
module tb_huffman_table_encoder;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 10;      // pipeline: table read, accumulate, serializer, output register
    localparam int CYCLE_LIMIT  = 200000;

    // One result of the encoder as it should appear on the m_ channel.
    typedef struct {
        hte_pkg::kind_t kind;
        logic [7:0]     pbyte;
        logic [31:0]    total;
        logic           last;
    } enc_result_t;

    // Mirror of the code table and the bit packer plus the queue of results
    // still owed by the block.
    class encoder_scoreboard;
        bit          tbl_valid [hte_pkg::SYMBOL_COUNT_DEF];
        logic [5:0]  tbl_len   [hte_pkg::SYMBOL_COUNT_DEF];
        logic [31:0] tbl_code  [hte_pkg::SYMBOL_COUNT_DEF];
        logic [6:0]  pend_bits;
        int unsigned pend_cnt;
        logic [31:0] total_bits;
        enc_result_t owed_q[$];
        int unsigned errors;

        function new();
            foreach (tbl_valid[i]) begin
                tbl_valid[i] = 1'b0;
                tbl_len[i]   = '0;
                tbl_code[i]  = '0;
            end
            pend_bits  = '0;
            pend_cnt   = 0;
            total_bits = '0;
            errors     = 0;
        endfunction

        function void owe(hte_pkg::kind_t kind, logic [7:0] pbyte, logic [31:0] total,
                          logic last);
            enc_result_t r;
            r.kind  = kind;
            r.pbyte = pbyte;
            r.total = total;
            r.last  = last;
            owed_q = {owed_q, r};
        endfunction

        // Update the mirror with one accepted input transaction.
        function void note_item(hte_pkg::op_t op, logic [7:0] sym, logic [5:0] len,
                                logic [31:0] bits);
            logic [63:0] acc;
            int unsigned cnt;
            case (op)
                hte_pkg::OP_LOAD: begin
                    if (len <= hte_pkg::MAX_CODE_LEN_DEF) begin
                        tbl_valid[sym] = 1'b1;
                        tbl_len[sym]   = len;
                        tbl_code[sym]  = (len < 32) ? bits & 32'((64'd1 << len) - 1) : bits;
                    end
                end
                hte_pkg::OP_ENCODE: begin
                    if (!tbl_valid[sym]) begin
                        owe(hte_pkg::KIND_ERROR, 8'h00, total_bits, 1'b1);
                    end else begin
                        acc = ({57'd0, pend_bits} << tbl_len[sym]) | {32'd0, tbl_code[sym]};
                        cnt = pend_cnt + tbl_len[sym];
                        total_bits = total_bits + 32'(tbl_len[sym]);
                        while (cnt >= 8) begin
                            cnt -= 8;
                            owe(hte_pkg::KIND_BYTE, 8'(acc >> cnt), total_bits, cnt < 8);
                        end
                        pend_cnt  = cnt;
                        pend_bits = 7'(acc & ((64'd1 << cnt) - 1));
                    end
                end
                hte_pkg::OP_FLUSH: begin
                    if (pend_cnt > 0)
                        owe(hte_pkg::KIND_BYTE, 8'({1'b0, pend_bits} << (8 - pend_cnt)),
                            total_bits, 1'b0);
                    owe(hte_pkg::KIND_FLUSH, 8'h00, total_bits, 1'b1);
                    pend_bits  = '0;
                    pend_cnt   = 0;
                    total_bits = '0;
                end
                default: begin
                    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
                    pend_bits  = '0;
                    pend_cnt   = 0;
                    total_bits = '0;
                end
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        // Check one m_ transaction against the oldest owed result.
        function void check_result(hte_pkg::kind_t kind, logic [7:0] pbyte,
                                   logic [31:0] total, logic last);
            enc_result_t want;
            if (owed_q.size() == 0) begin
                $display({"%0t: unexpected result: expected none, ",
                          "actual kind %0d byte %0h total %0h last %0b"},
                         $time, kind, pbyte, total, last);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            compare("kind", 32'(want.kind), 32'(kind));
            compare("packed_byte", 32'(want.pbyte), 32'(pbyte));
            compare("bit_total", want.total, total);
            compare("last", 32'(want.last), 32'(last));
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;   // symbol[7:0], code_len[13:8], code_bits[45:14], zero
    logic [1:0]  s_tuser  = '0;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // packed_byte[7:0], bit_total[39:8]
    logic [1:0]  m_tuser;         // kind[1:0]
    logic        m_tlast;

    encoder_scoreboard sb = new();

    int unsigned gap_pct   = 0;   // chance in percent of a sender gap before a transaction
    int unsigned stall_pct = 0;   // chance in percent per cycle of a receiver stall burst
    int unsigned hold_cnt  = 0;
    int unsigned cycles    = 0;
    int          live_syms[$];    // symbols with a loaded entry, duplicates allowed

    huffman_table_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Abort a hung run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: drop m_tready in random bursts, at a rate set per phase.
    always @(posedge aclk) begin
        if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= (hold_cnt == 1);
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            hold_cnt <= $urandom_range(1, 6);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every result transaction; values are sampled before this edge's updates.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(hte_pkg::kind_t'(m_tuser), m_tdata[7:0], m_tdata[39:8], m_tlast);
    end

    // Send one transaction, with an optional gap in front; hold it until accepted.
    task automatic send_item(hte_pkg::op_t op, logic [7:0] sym, logic [5:0] len,
                             logic [31:0] bits);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, bits, len, sym};
        do @(posedge aclk); while (!s_tready);
        sb.note_item(op, sym, len, bits);
        if (op == hte_pkg::OP_LOAD && len <= hte_pkg::MAX_CODE_LEN_DEF)
            live_syms = {live_syms, int'(sym)};
        if (op == hte_pkg::OP_CLEAR)
            live_syms.delete();
    endtask

    // Hold the sender until the block has delivered every owed result.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Mostly short codes, some long ones, a few empty, a few out of range.
    function automatic logic [5:0] pick_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)  return 6'd0;
        if (r < 80) return 6'($urandom_range(1, 12));
        if (r < 93) return 6'($urandom_range(13, 31));
        if (r < 97) return 6'd32;
        return 6'($urandom_range(33, 63));
    endfunction

    // Favor loaded symbols; now and then hit an arbitrary one.
    function automatic logic [7:0] pick_symbol();
        if (live_syms.size() != 0 && $urandom_range(0, 19) != 0)
            return 8'(live_syms[$urandom_range(0, live_syms.size() - 1)]);
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic load_table(int unsigned count);
        repeat (count)
            send_item(hte_pkg::OP_LOAD, 8'($urandom_range(0, 255)),
                      6'($urandom_range(1, 16)), $urandom());
    endtask

    task automatic run_random(int unsigned count);
        int unsigned r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_item(hte_pkg::OP_LOAD, 8'($urandom_range(0, 255)), pick_len(), $urandom());
            end else if (r < 84) begin
                // encode ignores length and code fields; randomize them anyway
                send_item(hte_pkg::OP_ENCODE, pick_symbol(), 6'($urandom()), $urandom());
            end else if (r < 96) begin
                send_item(hte_pkg::OP_FLUSH, 8'($urandom()), 6'($urandom()), $urandom());
            end else begin
                send_item(hte_pkg::OP_CLEAR, 8'($urandom()), 6'($urandom()), $urandom());
                load_table(10);
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed corner cases, light idling on both sides.
        gap_pct   = 25;
        stall_pct = 25;
        send_item(hte_pkg::OP_ENCODE, 8'h00, 6'd0,  32'd0);          // empty table: error
        send_item(hte_pkg::OP_LOAD,   8'h00, 6'd0,  32'hFFFF_FFFF);  // empty code
        send_item(hte_pkg::OP_ENCODE, 8'h00, 6'd0,  32'd0);          // adds no bits
        send_item(hte_pkg::OP_LOAD,   8'hFF, 6'd32, 32'hFFFF_FFFF);  // longest code
        send_item(hte_pkg::OP_LOAD,   8'h01, 6'd33, 32'h0000_AAAA);  // too long: ignored
        send_item(hte_pkg::OP_LOAD,   8'h02, 6'd63, 32'd0);          // too long: ignored
        send_item(hte_pkg::OP_LOAD,   8'h03, 6'd7,  32'hFFFF_FFD5);  // upper bits dropped
        send_item(hte_pkg::OP_ENCODE, 8'h03, 6'd0,  32'd0);          // seven bits wait
        send_item(hte_pkg::OP_ENCODE, 8'hFF, 6'd0,  32'd0);          // 39 bits: four bytes
        send_item(hte_pkg::OP_ENCODE, 8'h01, 6'd0,  32'd0);          // ignored load: error
        send_item(hte_pkg::OP_FLUSH,  8'h00, 6'd0,  32'd0);          // padded byte, report
        send_item(hte_pkg::OP_FLUSH,  8'h00, 6'd0,  32'd0);          // nothing pending
        send_item(hte_pkg::OP_LOAD,   8'h80, 6'd1,  32'h0000_0001);
        send_item(hte_pkg::OP_LOAD,   8'h7F, 6'd8,  32'h0000_00A5);
        send_item(hte_pkg::OP_ENCODE, 8'h80, 6'd0,  32'd0);
        send_item(hte_pkg::OP_ENCODE, 8'h7F, 6'd0,  32'd0);
        send_item(hte_pkg::OP_LOAD,   8'h40, 6'd32, 32'h8000_0001);
        send_item(hte_pkg::OP_ENCODE, 8'h40, 6'd0,  32'd0);
        send_item(hte_pkg::OP_FLUSH,  8'h00, 6'd0,  32'd0);
        send_item(hte_pkg::OP_CLEAR,  8'hFF, 6'h3F, 32'hFFFF_FFFF);
        send_item(hte_pkg::OP_ENCODE, 8'hFF, 6'd0,  32'd0);          // cleared: error
        send_item(hte_pkg::OP_FLUSH,  8'h00, 6'd0,  32'd0);

        // Pause the sender until every owed result is out.
        drain();

        // Mixed traffic with idling on both sides.
        gap_pct   = 20;
        stall_pct = 20;
        load_table(24);
        run_random(100);

        // Heavy back-pressure, sender always ready.
        gap_pct   = 0;
        stall_pct = 45;
        run_random(100);

        // Closing stretch at full rate.
        stall_pct = 0;
        run_random(100);

        drain();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/hte_pkg.sv
src/hte_table.sv
src/hte_emitter.sv
src/huffman_table_encoder.sv
verif/tb_huffman_table_encoder.sv
